### hw/rtl/yuv_channel_shift_defines.svh
// Assertion macros shared by the channel shift RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef YUV_CHANNEL_SHIFT_DEFINES_SVH
`define YUV_CHANNEL_SHIFT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define YCS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define YCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ycs_pkg.sv
// Shared types, constants and helpers for the YUV channel shift block.
// No dependencies; every other RTL file but the assertion macro header refers to this package.
`default_nettype none

package ycs_pkg;

  // Field widths fixed by the pixel format.
  localparam int SAMPLE_W  = 8;
  localparam int COORD_W   = 8;
  localparam int SHIFT_W   = 8;
  localparam int SIZE_W    = 9;
  localparam int POS_W     = COORD_W + 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = SIZE_W;

  // Default frame store geometry.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Channel slots.
  localparam int NUM_CH  = 3;
  localparam int CH_LUMA = 0;
  localparam int CH_CB   = 1;
  localparam int CH_CR   = 2;

  localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = 8'sd100;
  localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = -8'sd100;
  localparam logic [SIZE_W-1:0] DEF_FRAME_SIZE = 9'd256;
  localparam logic [SAMPLE_W-1:0] HALF_SCALE = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUMA_SHIFT_X = 3'd0,
    REG_LUMA_SHIFT_Y = 3'd1,
    REG_CB_SHIFT_X   = 3'd2,
    REG_CB_SHIFT_Y   = 3'd3,
    REG_CR_SHIFT_X   = 3'd4,
    REG_CR_SHIFT_Y   = 3'd5,
    REG_FRAME_WIDTH  = 3'd6,
    REG_FRAME_HEIGHT = 3'd7
  } cfg_idx_t;

  // Source position of one channel and whether it falls inside the frame.
  typedef struct packed {
    logic              hit;
    logic [SIZE_W-1:0] row;
    logic [SIZE_W-1:0] col;
  } chan_pos_t;

  // One classified command as it travels from front to back.
  typedef struct packed {
    logic                              is_read;
    chan_pos_t [NUM_CH-1:0]            pos;
    logic [NUM_CH-1:0][SAMPLE_W-1:0]   sample;
  } cmd_t;

  // Saturate a written shift value to the allowed range.
  function automatic logic signed [SHIFT_W-1:0] clamp_shift(input logic [SHIFT_W-1:0] value);
    logic signed [SHIFT_W-1:0] v;
    v = $signed(value);
    if (v > SHIFT_MAX) begin
      return SHIFT_MAX;
    end else if (v < SHIFT_MIN) begin
      return SHIFT_MIN;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ycs_stream_if.sv
// Valid/ready channel interfaces for pixel requests and shifted pixel results.
// Depends on ycs_pkg for field widths.
`default_nettype none

interface ycs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ycs_pkg::COORD_W-1:0]   pix_row;
  logic [ycs_pkg::COORD_W-1:0]   pix_col;
  logic [ycs_pkg::SAMPLE_W-1:0]  luma_in;
  logic [ycs_pkg::SAMPLE_W-1:0]  cb_in;
  logic [ycs_pkg::SAMPLE_W-1:0]  cr_in;

  modport source (output valid, req_type, pix_row, pix_col, luma_in, cb_in, cr_in,
                  input ready);
  modport sink (input valid, req_type, pix_row, pix_col, luma_in, cb_in, cr_in,
                output ready);
endinterface

interface ycs_out_if;
  logic                          valid;
  logic                          ready;
  logic [ycs_pkg::SAMPLE_W-1:0]  luma_out;
  logic [ycs_pkg::SAMPLE_W-1:0]  cb_out;
  logic [ycs_pkg::SAMPLE_W-1:0]  cr_out;

  modport source (output valid, luma_out, cb_out, cr_out, input ready);
  modport sink (input valid, luma_out, cb_out, cr_out, output ready);
endinterface

`default_nettype wire

### hw/rtl/ycs_front.sv
// Front end: configuration registers, request acceptance and classification.
// Depends on ycs_pkg and ycs_in_if; feeds classified commands to ycs_queue.
`default_nettype none

module ycs_front #(
  parameter int MAX_WIDTH  = ycs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ycs_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  ycs_in_if.sink                                in_if,
  input  wire logic                             cfg_we,
  input  wire logic [ycs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [ycs_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic                             q_ready,
  output      logic                             q_push,
  output      ycs_pkg::cmd_t                    q_data
);

  // Store limits seen through the 9-bit size registers.
  localparam int SizeMax = (1 << ycs_pkg::SIZE_W) - 1;
  localparam logic [ycs_pkg::SIZE_W-1:0] W_CAP =
    ycs_pkg::SIZE_W'((MAX_WIDTH > SizeMax) ? SizeMax : MAX_WIDTH);
  localparam logic [ycs_pkg::SIZE_W-1:0] H_CAP =
    ycs_pkg::SIZE_W'((MAX_HEIGHT > SizeMax) ? SizeMax : MAX_HEIGHT);

  logic signed [ycs_pkg::SHIFT_W-1:0] shift_x_r [ycs_pkg::NUM_CH];
  logic signed [ycs_pkg::SHIFT_W-1:0] shift_y_r [ycs_pkg::NUM_CH];
  logic [ycs_pkg::SIZE_W-1:0]         frame_width_r;
  logic [ycs_pkg::SIZE_W-1:0]         frame_height_r;
  logic [ycs_pkg::SIZE_W-1:0]         w_eff;
  logic [ycs_pkg::SIZE_W-1:0]         h_eff;

  // Configuration writes; shift values saturate on the way in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ycs_pkg::NUM_CH; k++) begin
        shift_x_r[k] <= '0;
        shift_y_r[k] <= '0;
      end
      frame_width_r  <= ycs_pkg::DEF_FRAME_SIZE;
      frame_height_r <= ycs_pkg::DEF_FRAME_SIZE;
    end else if (cfg_we) begin
      unique case (ycs_pkg::cfg_idx_t'(cfg_idx))
        ycs_pkg::REG_LUMA_SHIFT_X:
          shift_x_r[ycs_pkg::CH_LUMA] <= ycs_pkg::clamp_shift(cfg_wdata[ycs_pkg::SHIFT_W-1:0]);
        ycs_pkg::REG_LUMA_SHIFT_Y:
          shift_y_r[ycs_pkg::CH_LUMA] <= ycs_pkg::clamp_shift(cfg_wdata[ycs_pkg::SHIFT_W-1:0]);
        ycs_pkg::REG_CB_SHIFT_X:
          shift_x_r[ycs_pkg::CH_CB] <= ycs_pkg::clamp_shift(cfg_wdata[ycs_pkg::SHIFT_W-1:0]);
        ycs_pkg::REG_CB_SHIFT_Y:
          shift_y_r[ycs_pkg::CH_CB] <= ycs_pkg::clamp_shift(cfg_wdata[ycs_pkg::SHIFT_W-1:0]);
        ycs_pkg::REG_CR_SHIFT_X:
          shift_x_r[ycs_pkg::CH_CR] <= ycs_pkg::clamp_shift(cfg_wdata[ycs_pkg::SHIFT_W-1:0]);
        ycs_pkg::REG_CR_SHIFT_Y:
          shift_y_r[ycs_pkg::CH_CR] <= ycs_pkg::clamp_shift(cfg_wdata[ycs_pkg::SHIFT_W-1:0]);
        ycs_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        ycs_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
      endcase
    end
  end

  // Active frame size, limited to what the store holds.
  assign w_eff = (frame_width_r > W_CAP) ? W_CAP : frame_width_r;
  assign h_eff = (frame_height_r > H_CAP) ? H_CAP : frame_height_r;

  // Handshake: take an item whenever the queue has room.
  assign in_if.ready = q_ready;
  assign q_push      = in_if.valid && q_ready;

  // Classify the request and work out each channel's source position.
  always_comb begin
    logic signed [ycs_pkg::POS_W-1:0] r_pos;
    logic signed [ycs_pkg::POS_W-1:0] c_pos;
    logic                             in_store;
    r_pos = '0;
    c_pos = '0;
    q_data = '0;
    q_data.is_read = (in_if.req_type == ycs_pkg::REQ_READ);
    q_data.sample[ycs_pkg::CH_LUMA] = in_if.luma_in;
    q_data.sample[ycs_pkg::CH_CB]   = in_if.cb_in;
    q_data.sample[ycs_pkg::CH_CR]   = in_if.cr_in;
    in_store = (ycs_pkg::SIZE_W'(in_if.pix_row) < H_CAP) &&
               (ycs_pkg::SIZE_W'(in_if.pix_col) < W_CAP);
    for (int k = 0; k < ycs_pkg::NUM_CH; k++) begin
      if (q_data.is_read) begin
        r_pos = $signed({2'b00, in_if.pix_row}) + ycs_pkg::POS_W'(shift_y_r[k]);
        c_pos = $signed({2'b00, in_if.pix_col}) + ycs_pkg::POS_W'(shift_x_r[k]);
        q_data.pos[k].hit = !r_pos[ycs_pkg::POS_W-1] && !c_pos[ycs_pkg::POS_W-1] &&
                            (r_pos[ycs_pkg::SIZE_W-1:0] < h_eff) &&
                            (c_pos[ycs_pkg::SIZE_W-1:0] < w_eff);
        q_data.pos[k].row = r_pos[ycs_pkg::SIZE_W-1:0];
        q_data.pos[k].col = c_pos[ycs_pkg::SIZE_W-1:0];
      end else begin
        q_data.pos[k].hit = in_store;
        q_data.pos[k].row = ycs_pkg::SIZE_W'(in_if.pix_row);
        q_data.pos[k].col = ycs_pkg::SIZE_W'(in_if.pix_col);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ycs_queue.sv
// Short command queue that decouples the front end from the store back end.
// Depends on ycs_pkg for the command type and depth; uses the assertion macros.
`default_nettype none
`include "yuv_channel_shift_defines.svh"

module ycs_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ycs_pkg::cmd_t  push_data,
  output      logic           push_ready,
  output      logic           head_valid,
  output      ycs_pkg::cmd_t  head_data,
  input  wire logic           pop
);

  localparam logic [ycs_pkg::CNT_W-1:0] FULL_COUNT = ycs_pkg::CNT_W'(ycs_pkg::QUEUE_DEPTH);

  ycs_pkg::cmd_t                  entry_r [ycs_pkg::QUEUE_DEPTH];
  logic [ycs_pkg::PTR_W-1:0]      head_r;
  logic [ycs_pkg::PTR_W-1:0]      tail_r;
  logic [ycs_pkg::CNT_W-1:0]      count_r;
  logic [ycs_pkg::CNT_W-1:0]      count_nxt;

  assign push_ready = (count_r != FULL_COUNT);
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[head_r];

  // Occupancy after this cycle's transfers.
  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        tail_r <= tail_r + 1'b1;
      end
      if (pop) begin
        head_r <= head_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[tail_r] <= push_data;
    end
  end

  `YCS_ASSERT_IMPLIES(a_count_bound, 1'b1, count_r <= FULL_COUNT, "queue occupancy above depth")
  `YCS_ASSERT_IMPLIES(a_pop_nonempty, pop, count_r != '0, "pop from an empty queue")
  `YCS_ASSERT_IMPLIES(a_push_room, push, count_r != FULL_COUNT, "push into a full queue")

endmodule

`default_nettype wire

### hw/rtl/ycs_back.sv
// Back end: Y, U and V frame stores, registered reads and the result channel.
// Depends on ycs_pkg and ycs_out_if; takes commands from ycs_queue.
`default_nettype none
`include "yuv_channel_shift_defines.svh"

module ycs_back #(
  parameter int MAX_WIDTH  = ycs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ycs_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire ycs_pkg::cmd_t  q_data,
  output      logic           q_pop,
  ycs_out_if.source           out_if
);

  localparam int RW          = $clog2(MAX_HEIGHT);
  localparam int CW          = $clog2(MAX_WIDTH);
  localparam int ADDR_W      = RW + CW;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  logic                                  s1_valid_r;
  logic [ycs_pkg::NUM_CH-1:0]            hit_r;
  logic [ycs_pkg::NUM_CH-1:0][ycs_pkg::SAMPLE_W-1:0] rd_data;
  logic                                  rd_en;

  // Writes always drain; a read needs the result register free or leaving.
  assign q_pop = q_valid && (!q_data.is_read || !s1_valid_r || out_if.ready);
  assign rd_en = q_pop && q_data.is_read;

  // One store per channel, one write or one read port use per cycle.
  for (genvar k = 0; k < ycs_pkg::NUM_CH; k++) begin : g_store
    logic [ycs_pkg::SAMPLE_W-1:0] store_r [STORE_DEPTH];
    logic [ycs_pkg::SAMPLE_W-1:0] rd_r;
    logic [ADDR_W-1:0]            store_addr;
    logic                         store_we;

    assign store_addr = {RW'(q_data.pos[k].row), CW'(q_data.pos[k].col)};
    assign store_we   = q_pop && !q_data.is_read && q_data.pos[k].hit;
    assign rd_data[k] = rd_r;

    always_ff @(posedge clk) begin
      if (store_we) begin
        store_r[store_addr] <= q_data.sample[k];
      end
      if (rd_en) begin
        rd_r <= store_r[store_addr];
      end
    end
  end

  // Result register control; read data holds until the transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (rd_en) begin
      s1_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      for (int k = 0; k < ycs_pkg::NUM_CH; k++) begin
        hit_r[k] <= q_data.pos[k].hit;
      end
    end
  end

  // Out-of-frame channels read as black luma and neutral chroma.
  assign out_if.valid    = s1_valid_r;
  assign out_if.luma_out = hit_r[ycs_pkg::CH_LUMA] ? rd_data[ycs_pkg::CH_LUMA] : '0;
  assign out_if.cb_out   = hit_r[ycs_pkg::CH_CB] ? rd_data[ycs_pkg::CH_CB] : ycs_pkg::HALF_SCALE;
  assign out_if.cr_out   = hit_r[ycs_pkg::CH_CR] ? rd_data[ycs_pkg::CH_CR] : ycs_pkg::HALF_SCALE;

  `YCS_ASSERT_NEXT(a_result_kept, s1_valid_r && !out_if.ready, s1_valid_r, "pending result dropped")
  `YCS_ASSERT_NEXT(a_hit_kept, s1_valid_r && !out_if.ready, $stable(hit_r), "pending result flags changed")
  `YCS_ASSERT_IMPLIES(a_result_from_read, $rose(s1_valid_r), $past(rd_en), "result without a store read")

endmodule

`default_nettype wire

### hw/rtl/yuv_channel_shift.sv
// A read request passes through the command queue, then its store read fills the result
// register, from which the result transfers; writes give none.
// Throughput: one request per cycle while the queue has room, set by single-port stores.
// A stalled result channel holds the back end; four queued commands then stop the input.
// Reset (rst_n, synchronous) zeroes all shifts, sets a 256 x 256 frame and empties the queue.
// The frame stores are not cleared; only written entries have defined contents.
`default_nettype none

module yuv_channel_shift #(
  parameter int MAX_WIDTH  = ycs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ycs_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ycs_in_if.sink                              in_if,
  ycs_out_if.source                           out_if,
  input  wire logic                           cfg_we,
  input  wire logic [ycs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [ycs_pkg::CFG_W-1:0]      cfg_wdata
);

  logic           push;
  logic           push_ready;
  ycs_pkg::cmd_t  push_data;
  logic           head_valid;
  ycs_pkg::cmd_t  head_data;
  logic           pop;

  // Request acceptance and classification.
  ycs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .q_ready   (push_ready),
    .q_push    (push),
    .q_data    (push_data)
  );

  // Command queue between the two halves.
  ycs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  // Frame stores and result channel.
  ycs_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (head_valid),
    .q_data  (head_data),
    .q_pop   (pop),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire

### verif/yuv_channel_shift_tb.sv
// Self-checking testbench for yuv_channel_shift: drives pixel writes and shifted reads,
// predicts every read result from its own copy of the frame store and registers.
// Depends on ycs_pkg, the ycs_in_if and ycs_out_if interfaces and the yuv_channel_shift RTL.

module yuv_channel_shift_tb;
  import ycs_pkg::*;

  localparam int FRAME_MAX       = 256;
  localparam int SHIFT_BOUND     = 100;
  localparam logic [SAMPLE_W-1:0] MID_SAMPLE = 8'h80;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int STALL_LIMIT     = 1000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] luma;
    logic [SAMPLE_W-1:0] cb;
    logic [SAMPLE_W-1:0] cr;
  } yuv_pix_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  ycs_in_if  in_ch ();
  ycs_out_if out_ch ();

  yuv_channel_shift u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the frame store and registers as the block should hold them.
  logic [SAMPLE_W-1:0] luma_mem [FRAME_MAX*FRAME_MAX];
  logic [SAMPLE_W-1:0] cb_mem [FRAME_MAX*FRAME_MAX];
  logic [SAMPLE_W-1:0] cr_mem [FRAME_MAX*FRAME_MAX];
  bit written [FRAME_MAX*FRAME_MAX];
  int written_list [$];
  int last_write_idx = 0;
  int dx_q [NUM_CH] = '{0, 0, 0};
  int dy_q [NUM_CH] = '{0, 0, 0};
  int width_q = FRAME_MAX;
  int height_q = FRAME_MAX;

  yuv_pix_t pending_pixels [$];
  int mismatch_count = 0;
  bit pace_on = 1'b1;
  bit hold_off_req = 1'b0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Store index of one channel's source position; true when it lies inside the frame.
  function automatic bit source_index(input int ch, input int row, input int col,
                                      output int idx);
    int w;
    int h;
    int r;
    int c;
    w = (width_q > FRAME_MAX) ? FRAME_MAX : width_q;
    h = (height_q > FRAME_MAX) ? FRAME_MAX : height_q;
    r = row + dy_q[ch];
    c = col + dx_q[ch];
    idx = r * FRAME_MAX + c;
    return (r >= 0) && (r < h) && (c >= 0) && (c < w);
  endfunction

  // Output pixel for a read at the given position.
  function automatic yuv_pix_t shifted_pixel(input int row, input int col);
    yuv_pix_t px;
    int idx;
    px.luma = '0;
    px.cb = MID_SAMPLE;
    px.cr = MID_SAMPLE;
    if (source_index(CH_LUMA, row, col, idx)) px.luma = luma_mem[idx];
    if (source_index(CH_CB, row, col, idx)) px.cb = cb_mem[idx];
    if (source_index(CH_CR, row, col, idx)) px.cr = cr_mem[idx];
    return px;
  endfunction

  // A read is allowed only if no channel lands on a never-written entry.
  function automatic bit read_is_safe(input int row, input int col);
    int idx;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (source_index(ch, row, col, idx) && !written[idx]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [CFG_W-1:0] random_shift_code();
    int r;
    int v;
    logic [CFG_W-1:0] code;
    r = $urandom_range(0, 9);
    if (r >= 8) return CFG_W'($urandom_range(0, 511));
    if (r < 5) begin
      v = $urandom_range(0, 16);
      v = v - 8;
    end else begin
      v = $urandom_range(0, 2 * SHIFT_BOUND);
      v = v - SHIFT_BOUND;
    end
    code = CFG_W'(8'(v));
    code[CFG_W-1] = 1'($urandom_range(0, 1));
    return code;
  endfunction

  function automatic logic [CFG_W-1:0] random_frame_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return CFG_W'($urandom_range(1, 16));
    if (r == 6) return '0;
    if (r == 7) return CFG_W'(FRAME_MAX);
    if (r == 8) return CFG_W'($urandom_range(257, 511));
    return CFG_W'($urandom_range(17, 255));
  endfunction

  // Offer one request and hold it until the transfer; then update the mirror.
  task automatic send_request(input req_t kind, input logic [COORD_W-1:0] row,
                              input logic [COORD_W-1:0] col, input logic [SAMPLE_W-1:0] y,
                              input logic [SAMPLE_W-1:0] u, input logic [SAMPLE_W-1:0] v);
    int gap;
    int idx;
    gap = pace_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.pix_row  <= row;
    in_ch.pix_col  <= col;
    in_ch.luma_in  <= y;
    in_ch.cb_in    <= u;
    in_ch.cr_in    <= v;
    do @(posedge clk); while (!in_ch.ready);
    if (kind == REQ_WRITE) begin
      idx = int'(row) * FRAME_MAX + int'(col);
      luma_mem[idx] = y;
      cb_mem[idx] = u;
      cr_mem[idx] = v;
      last_write_idx = idx;
      if (!written[idx]) begin
        written[idx] = 1'b1;
        written_list.push_back(idx);
      end
    end else begin
      pending_pixels.push_back(shifted_pixel(row, col));
    end
  endtask

  // Drop valid, let every result come back and the pipeline drain.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes mostly land near the active frame so that later reads find data.
  task automatic send_random_write();
    int span_r;
    int span_c;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    span_r = ((height_q > FRAME_MAX - 8) ? FRAME_MAX - 8 : height_q) + 8;
    span_c = ((width_q > FRAME_MAX - 8) ? FRAME_MAX - 8 : width_q) + 8;
    if ($urandom_range(0, 2) != 0) begin
      row = COORD_W'($urandom_range(0, span_r - 1));
      col = COORD_W'($urandom_range(0, span_c - 1));
    end else begin
      row = COORD_W'($urandom);
      col = COORD_W'($urandom);
    end
    send_request(REQ_WRITE, row, col, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                 SAMPLE_W'($urandom));
  endtask

  // Read aimed so that one channel hits stored data; falls back to a write
  // when no position is found that avoids never-written entries.
  task automatic send_probe();
    int r;
    int c;
    int ch;
    int tgt;
    bit found;
    found = 1'b0;
    for (int tries = 0; tries < 24 && !found; tries++) begin
      r = $urandom_range(0, FRAME_MAX - 1);
      c = $urandom_range(0, FRAME_MAX - 1);
      if (written_list.size() > 0 && $urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 4) == 0) tgt = last_write_idx;
        else tgt = written_list[$urandom_range(0, written_list.size() - 1)];
        ch = $urandom_range(0, NUM_CH - 1);
        if (tgt / FRAME_MAX - dy_q[ch] inside {[0:FRAME_MAX-1]} &&
            tgt % FRAME_MAX - dx_q[ch] inside {[0:FRAME_MAX-1]}) begin
          r = tgt / FRAME_MAX - dy_q[ch];
          c = tgt % FRAME_MAX - dx_q[ch];
        end
      end
      found = read_is_safe(r, c);
    end
    if (found) begin
      send_request(REQ_READ, COORD_W'(r), COORD_W'(c), SAMPLE_W'($urandom),
                   SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    end else begin
      send_random_write();
    end
  endtask

  task automatic run_mix(input int count, input int read_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < read_pct) send_probe();
      else send_random_write();
    end
  endtask

  // Program all eight registers while idle, optionally filling a small frame.
  task automatic apply_regs(input logic [CFG_W-1:0] lx, input logic [CFG_W-1:0] ly,
                            input logic [CFG_W-1:0] bx, input logic [CFG_W-1:0] by,
                            input logic [CFG_W-1:0] rx, input logic [CFG_W-1:0] ry,
                            input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input bit fill);
    logic [CFG_W-1:0] image [8];
    cfg_idx_t idx;
    int sat;
    int fw;
    int fh;
    image[REG_LUMA_SHIFT_X] = lx;
    image[REG_LUMA_SHIFT_Y] = ly;
    image[REG_CB_SHIFT_X]   = bx;
    image[REG_CB_SHIFT_Y]   = by;
    image[REG_CR_SHIFT_X]   = rx;
    image[REG_CR_SHIFT_Y]   = ry;
    image[REG_FRAME_WIDTH]  = w;
    image[REG_FRAME_HEIGHT] = h;
    quiesce();
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx;
      cfg_wdata <= image[idx];
      @(posedge clk);
      // Shift codes use the low byte only and saturate at the bound.
      sat = $signed(image[idx][SHIFT_W-1:0]);
      if (sat > SHIFT_BOUND) sat = SHIFT_BOUND;
      if (sat < -SHIFT_BOUND) sat = -SHIFT_BOUND;
      case (idx)
        REG_LUMA_SHIFT_X: dx_q[CH_LUMA] = sat;
        REG_LUMA_SHIFT_Y: dy_q[CH_LUMA] = sat;
        REG_CB_SHIFT_X:   dx_q[CH_CB] = sat;
        REG_CB_SHIFT_Y:   dy_q[CH_CB] = sat;
        REG_CR_SHIFT_X:   dx_q[CH_CR] = sat;
        REG_CR_SHIFT_Y:   dy_q[CH_CR] = sat;
        REG_FRAME_WIDTH:  width_q = int'(image[idx]);
        REG_FRAME_HEIGHT: height_q = int'(image[idx]);
        default: ;
      endcase
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    // A small frame is written in full so that any read is defined.
    fw = (width_q > FRAME_MAX) ? FRAME_MAX : width_q;
    fh = (height_q > FRAME_MAX) ? FRAME_MAX : height_q;
    if (fill && fw * fh <= 256) begin
      for (int r = 0; r < fh; r++) begin
        for (int c = 0; c < fw; c++) begin
          send_request(REQ_WRITE, COORD_W'(r), COORD_W'(c), SAMPLE_W'($urandom),
                       SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end
      end
    end
  endtask

  task automatic apply_random_regs(input bit fill);
    apply_regs(random_shift_code(), random_shift_code(), random_shift_code(),
               random_shift_code(), random_shift_code(), random_shift_code(),
               random_frame_size(), random_frame_size(), fill);
  endtask

  // Reset values of the registers: corner pixels come back unshifted.
  task automatic test_reset_frame();
    send_request(REQ_WRITE, 8'd0, 8'd0, 8'h00, 8'hFF, 8'h01);
    send_request(REQ_WRITE, 8'd0, 8'd255, 8'h80, 8'h7F, 8'hAA);
    send_request(REQ_WRITE, 8'd255, 8'd0, 8'h55, 8'hAA, 8'hFE);
    send_request(REQ_WRITE, 8'd255, 8'd255, 8'hFF, 8'h00, 8'hFF);
    send_request(REQ_READ, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    send_request(REQ_READ, 8'd0, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    send_request(REQ_READ, 8'd255, 8'd0, 8'h00, 8'h00, 8'h00);
    send_request(REQ_READ, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // Shift codes beyond the range saturate; bit 8 of the write data is ignored.
  task automatic test_shift_saturation();
    apply_regs(9'h07F, 9'h180, 9'h065, 9'h09B, 9'h164, 9'h09C, 9'h100, 9'h100, 1'b0);
    send_request(REQ_WRITE, 8'd100, 8'd100, 8'h3C, 8'hC3, 8'h5A);
    send_request(REQ_READ, 8'd200, 8'd0, 8'h00, 8'h00, 8'h00);
    send_request(REQ_READ, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    send_request(REQ_READ, 8'd255, 8'd255, 8'h00, 8'h00, 8'h00);
  endtask

  // Zero, oversized and single-pixel frames, and reads requested outside the frame.
  task automatic test_frame_bounds();
    apply_regs(9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h100, 1'b0);
    send_request(REQ_READ, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    send_request(REQ_READ, 8'd255, 8'd255, 8'h00, 8'h00, 8'h00);
    apply_regs(9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h1FF, 9'h12C, 1'b0);
    send_request(REQ_READ, 8'd255, 8'd255, 8'h00, 8'h00, 8'h00);
    send_request(REQ_READ, 8'd0, 8'd255, 8'h00, 8'h00, 8'h00);
    apply_regs(9'h0FD, 9'h000, 9'h000, 9'h0F9, 9'h002, 9'h002, 9'h001, 9'h001, 1'b0);
    send_request(REQ_READ, 8'd0, 8'd3, 8'h00, 8'h00, 8'h00);
    send_request(REQ_READ, 8'd7, 8'd0, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_random_settings();
    repeat (6) begin
      apply_random_regs(1'b1);
      run_mix(80, 65);
    end
  endtask

  // Full shifts in opposite directions, then all in one direction, then the smallest frame.
  task automatic test_extreme_settings();
    apply_regs(9'h064, 9'h09C, 9'h09C, 9'h064, 9'h064, 9'h064, 9'h100, 9'h100, 1'b0);
    run_mix(70, 70);
    apply_regs(9'h09C, 9'h09C, 9'h09C, 9'h09C, 9'h09C, 9'h09C, 9'h100, 9'h100, 1'b0);
    run_mix(50, 70);
    apply_regs(9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h001, 9'h001, 1'b1);
    run_mix(40, 60);
  endtask

  // Back-to-back traffic on both sides.
  task automatic test_full_rate();
    pace_on = 1'b0;
    apply_random_regs(1'b1);
    run_mix(150, 70);
    quiesce();
    pace_on = 1'b1;
  endtask

  // Long result stall while reads keep coming, so the input must stall too.
  task automatic test_backpressure();
    apply_regs(9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h00C, 9'h00A, 1'b1);
    pace_on = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) send_probe();
    quiesce();
    pace_on = 1'b1;
  endtask

  task automatic check_field(input string what, input logic [SAMPLE_W-1:0] want,
                             input logic [SAMPLE_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %02h, got %02h", $time, what, want, got);
    end
  endtask

  // Result side: check each transfer against the oldest expected pixel, then pace ready.
  initial begin : pixel_sink
    int stall_left;
    int gap;
    yuv_pix_t want;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_pixels.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result: expected none, got %02h %02h %02h", $time,
                   out_ch.luma_out, out_ch.cb_out, out_ch.cr_out);
        end else begin
          want = pending_pixels.pop_front();
          check_field("luma_out", want.luma, out_ch.luma_out);
          check_field("cb_out", want.cb, out_ch.cb_out);
          check_field("cr_out", want.cr, out_ch.cr_out);
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        gap = pace_on ? pick_gap() : 0;
        out_ch.ready <= (gap == 0);
        if (gap > 1) stall_left = gap - 1;
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("yuv_channel_shift_tb: errors");
    $finish;
  end

  // Reset, then the tests in turn, then drain and report.
  initial begin : stimulus
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_LUMA_SHIFT_X;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_WRITE;
    in_ch.pix_row  <= '0;
    in_ch.pix_col  <= '0;
    in_ch.luma_in  <= '0;
    in_ch.cb_in    <= '0;
    in_ch.cr_in    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_frame();
    test_shift_saturation();
    test_frame_bounds();
    test_random_settings();
    test_extreme_settings();
    test_backpressure();
    test_full_rate();
    quiesce();
    if (mismatch_count == 0) begin
      $display("yuv_channel_shift_tb: clean");
    end else begin
      $display("yuv_channel_shift_tb: errors");
    end
    $finish;
  end

endmodule
